>>> rtl/core/vfs_pkg.sv
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared types and constants for the video frame segmenter.
// ----------------------------------------------------------------------------
package vfs_pkg;

  // Segment position codes
  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_MIDDLE = 2'd1;
  localparam logic [1:0] POS_END    = 2'd2;
  localparam logic [1:0] POS_SINGLE = 2'd3;

  // Header bit values
  localparam logic [7:0] X_BIT    = 8'h80;
  localparam logic [7:0] S_BIT    = 8'h10;
  localparam logic [7:0] I_BIT    = 8'h80;
  localparam logic [7:0] SHOW_BIT = 8'h10;

  // Last allowed segment index within a frame
  localparam logic [5:0] SEG_MAX = 6'd63;

  // Descriptor queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input tdata and output tdata widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 112;

  // Frame descriptor as held in the queue
  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  source_id;
    logic        key_frame;
    logic [6:0]  picture_id;
    logic [31:0] frame_stamp;
  } desc_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic  not_empty;
    desc_t head;
  } queue_status_t;

endpackage

>>> rtl/core/video_frame_segmenter.sv
// ----------------------------------------------------------------------------
// video_frame_segmenter
// Splits encoded frame descriptors into per-segment payload headers.
//
//   Channel  Dir  Accepted when          Carries
//   s_*      in   s_tvalid && s_tready   one frame request
//   m_*      out  m_tvalid && m_tready   one segment header, tlast on last
//
// The segment sequencer loads each frame's descriptor from the queue, then
// emits one header per cycle while the output is not stalled.
// The front end takes one request per cycle while the four-entry queue has
// room; zero-length frames advance the counter and never reach the queue.
// Reset clears the frame counter, the queue and the sequencer.
// A stalled output holds its header and stops the sequencer; the front end
// keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module video_frame_segmenter import vfs_pkg::*; #(
  parameter int PAYLOAD_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // frame_length[15:0], source_id[23:16], picture_id[30:24], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // key_frame
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // position[1:0], source_out[9:2], segment_number[15:10], frame_stamp[47:16],
  // required_byte[55:48], extension_byte[63:56], picture_byte[70:64],
  // size_byte0[78:71], size_byte1[86:79], size_byte2[94:87],
  // chunk_length[107:95], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // last_segment
  output logic                  m_tlast
);

  logic          queue_full;
  logic          push;
  desc_t         push_desc;
  logic          pop;
  queue_status_t status;

  vfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  vfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (queue_full),
    .pop       (pop),
    .status    (status)
  );

  vfs_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/core/vfs_front.sv
// ----------------------------------------------------------------------------
// vfs_front
// Accepts frame descriptors, stamps them with the frame counter and queues
// every non-empty frame for the back end.
// ----------------------------------------------------------------------------
module vfs_front import vfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // frame_length, source_id, picture_id
  input  logic                 s_tuser,  // key_frame
  input  logic                 queue_full,
  output logic                 push,
  output desc_t                push_desc
);

  logic [31:0] frame_counter;
  logic        accept;

  // Take a request whenever the queue has room
  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;

  // Build the descriptor; empty frames only advance the counter
  always_comb begin
    push_desc.frame_length = s_tdata[15:0];
    push_desc.source_id    = s_tdata[23:16];
    push_desc.picture_id   = s_tdata[30:24];
    push_desc.key_frame    = s_tuser;
    push_desc.frame_stamp  = frame_counter;
    push = accept && (s_tdata[15:0] != 16'd0);
  end

  // Advance the frame counter on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= 32'd0;
    end else if (accept) begin
      frame_counter <= frame_counter + 32'd1;
    end
  end

endmodule

>>> rtl/core/vfs_queue.sv
// ----------------------------------------------------------------------------
// vfs_queue
// Short descriptor queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module vfs_queue import vfs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  desc_t         push_desc,
  output logic          full,
  input  logic          pop,
  output queue_status_t status
);

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full             = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.not_empty = (count != '0);
  assign status.head      = entries[rd_ptr];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/vfs_back.sv
// ----------------------------------------------------------------------------
// vfs_back
// Segment sequencer: walks one queued frame a segment per cycle while the
// output is free, and drives the registered header stream.
// ----------------------------------------------------------------------------
module vfs_back import vfs_pkg::*; #(
  parameter int PAYLOAD_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_status_t         status,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam logic [15:0] PAYLOAD_W = 16'(PAYLOAD_BYTES);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_BUSY = 1'b1;

  logic        state;
  desc_t       cur;
  logic [15:0] remaining;
  logic [5:0]  seg;
  logic        out_free;
  logic        emit;
  logic [15:0] chunk;
  logic        last;
  logic        first;
  logic [1:0]  position;
  logic [7:0]  required_byte;
  logic [7:0]  size_byte0;
  logic [7:0]  size_byte1;
  logic [7:0]  size_byte2;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == STATE_IDLE) && status.not_empty;
  assign emit     = (state == STATE_BUSY) && out_free;

  // Work out the header of the current segment
  always_comb begin
    chunk = (remaining > PAYLOAD_W) ? PAYLOAD_W : remaining;
    last  = (remaining <= PAYLOAD_W) || (seg == SEG_MAX);
    first = (seg == 6'd0);
    unique case ({first, last})
      2'b11:   position = POS_SINGLE;
      2'b10:   position = POS_START;
      2'b01:   position = POS_END;
      default: position = POS_MIDDLE;
    endcase
    required_byte = first ? (X_BIT | S_BIT) : X_BIT;
    if (first) begin
      size_byte0 = {cur.frame_length[2:0], 5'd0} | SHOW_BIT | {7'd0, !cur.key_frame};
      size_byte1 = cur.frame_length[10:3];
      size_byte2 = {3'd0, cur.frame_length[15:11]};
    end else begin
      size_byte0 = 8'd0;
      size_byte1 = 8'd0;
      size_byte2 = 8'd0;
    end
  end

  // Load a frame, then advance one segment per free output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
    end else begin
      unique case (state)
        STATE_IDLE: begin
          if (pop) begin
            state <= STATE_BUSY;
          end
        end
        default: begin
          if (emit && last) begin
            state <= STATE_IDLE;
          end
        end
      endcase
    end
  end

  // Hold the frame being segmented
  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= status.head;
      remaining <= status.head.frame_length;
      seg       <= 6'd0;
    end else if (emit) begin
      remaining <= remaining - chunk;
      seg       <= seg + 6'd1;
    end
  end

  // Output register: valid needs reset, payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {4'd0, chunk[12:0], size_byte2, size_byte1, size_byte0,
                  cur.picture_id, I_BIT, required_byte, cur.frame_stamp,
                  seg, cur.source_id, position};
      m_tlast <= last;
    end
  end

endmodule
